[design/sgb_pkg.sv]
// ----------------------------------------------------------------------------
// Separable blur package
// Shared constants, configuration and control types, and small helpers for
// tap lookup, border mirroring and 8-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_RADIUS_DEF = 11;
   localparam int HEIGHT_LIMIT   = 4096;

   localparam int ROW_W  = 12;
   localparam int IROW_W = 13;
   localparam int HGT_W  = 13;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_BLUR_RADIUS  = 3'd2;
   localparam logic [2:0] CSR_TAP_LOW      = 3'd3;
   localparam logic [2:0] CSR_TAP_MID      = 3'd4;
   localparam logic [2:0] CSR_TAP_HIGH     = 3'd5;

   localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [3:0]  BLUR_RADIUS_RST  = 4'd0;
   localparam logic [63:0] TAP_LOW_RST      = 64'd32768;

   typedef struct packed {
      logic [10:0]  frame_width;
      logic [12:0]  frame_height;
      logic [3:0]   blur_radius;
      logic [191:0] taps;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic update;
      logic blur_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic produce;
      logic blur_done;
      logic out_free;
   } status_type;

   function automatic logic [15:0] tap_of(input logic [191:0] taps, input logic [3:0] k);
      return taps[{k, 4'b0000} +: 16];
   endfunction

   function automatic logic [7:0] sat8(input logic [31:0] acc);
      logic [16:0] v;
      v = acc[31:15];
      return (v > 17'd255) ? 8'hFF : v[7:0];
   endfunction

   function automatic logic [13:0] mirror_coord(input logic [13:0] c,
                                                input logic signed [5:0] r,
                                                input logic [13:0] n);
      logic signed [15:0] sc;
      logic signed [15:0] sn;
      logic signed [15:0] sr;
      logic signed [15:0] p;
      sc = signed'({2'b00, c});
      sn = signed'({2'b00, n});
      sr = 16'(r);
      p  = sc + sr;
      if (p < 16'sd0 || p >= sn) begin
         p = sc - sr;
      end
      if (p < 16'sd0) begin
         p = 16'sd0;
      end
      if (p >= sn) begin
         p = sn - 16'sd1;
      end
      return p[13:0];
   endfunction

endpackage

`default_nettype wire

[design/sgb_csr.sv]
// ----------------------------------------------------------------------------
// Separable blur configuration registers
// Holds frame size, radius and tap words, written through the csr channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [2:0]      csr_index,
   input  wire logic [63:0]     csr_wdata,
   output sgb_pkg::cfg_type     cfg
);

   logic [10:0] frame_width_ff;
   logic [12:0] frame_height_ff;
   logic [3:0]  blur_radius_ff;
   logic [63:0] tap_low_ff;
   logic [63:0] tap_mid_ff;
   logic [63:0] tap_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sgb_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= sgb_pkg::FRAME_HEIGHT_RST;
         blur_radius_ff  <= sgb_pkg::BLUR_RADIUS_RST;
         tap_low_ff      <= sgb_pkg::TAP_LOW_RST;
         tap_mid_ff      <= '0;
         tap_high_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sgb_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[10:0];
            sgb_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[12:0];
            sgb_pkg::CSR_BLUR_RADIUS:  blur_radius_ff  <= csr_wdata[3:0];
            sgb_pkg::CSR_TAP_LOW:      tap_low_ff      <= csr_wdata;
            sgb_pkg::CSR_TAP_MID:      tap_mid_ff      <= csr_wdata;
            sgb_pkg::CSR_TAP_HIGH:     tap_high_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.frame_width  = frame_width_ff;
      cfg.frame_height = frame_height_ff;
      cfg.blur_radius  = blur_radius_ff;
      cfg.taps         = {tap_high_ff, tap_mid_ff, tap_low_ff};
   end

endmodule

`default_nettype wire

[design/sgb_ctrl.sv]
// ----------------------------------------------------------------------------
// Separable blur controller
// Sequences one request at a time through capture, position update, output
// decision and, for a result, the blur sweep and the output hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sgb_pkg::status_type status,
   output sgb_pkg::cmd_type         cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CALC   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_NEED   = 6'b001000,
      ST_BLUR   = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.skip ? ST_IDLE : ST_NEED;
         end
         ST_NEED: begin
            if (status.produce) begin
               cmd.blur_start = 1'b1;
               state_in       = ST_BLUR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BLUR: begin
            if (status.blur_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_done_in_blur: assert property (@(posedge clock) disable iff (reset)
      status.blur_done |-> state_ff == ST_BLUR)
      else $error("Blur sweep finished outside the blur state.");

   a_start_enters_blur: assert property (@(posedge clock) disable iff (reset)
      cmd.blur_start |=> state_ff == ST_BLUR)
      else $error("Blur start did not enter the blur state.");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !status.out_free) |=> state_ff == ST_EMIT)
      else $error("Result left the emit state while the output was busy.");

endmodule

`default_nettype wire

[design/sgb_dp.sv]
// ----------------------------------------------------------------------------
// Separable blur datapath
// Position counters, pixel history memory, the tap sweep pipeline with its
// vertical and horizontal accumulators, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_dp #(
   parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sgb_pkg::cfg_type cfg,
   input  wire sgb_pkg::cmd_type cmd,
   output sgb_pkg::status_type   status,
   input  wire logic             req_func,
   input  wire logic [7:0]       req_red_in,
   input  wire logic [7:0]       req_green_in,
   input  wire logic [7:0]       req_blue_in,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            rsp_red_out,
   output logic [7:0]            rsp_green_out,
   output logic [7:0]            rsp_blue_out,
   output logic                  rsp_frame_end
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = sgb_pkg::ROW_W;
   localparam int IROW_W = sgb_pkg::IROW_W;
   localparam int HGT_W  = sgb_pkg::HGT_W;
   localparam int LIN_W  = $clog2(MAX_WIDTH * sgb_pkg::HEIGHT_LIMIT) + 1;
   localparam int HIST   = MAX_WIDTH * 2 * MAX_RADIUS + 2 * MAX_RADIUS + 1;
   localparam int ADDR_W = $clog2(HIST);
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 1);
   localparam int ACC_W  = 24 + $clog2(2 * MAX_RADIUS + 1);
   localparam int PROD_W = ROW_W + WID_W;

   typedef struct packed {
      logic       first_v;
      logic       last_v;
      logic       first_h;
      logic       last_all;
      logic [3:0] vk;
      logic [3:0] hk;
   } tag_type;

   logic [WID_W-1:0] w;
   logic [HGT_W-1:0] h;
   logic [RAD_W-1:0] rad;

   always_comb begin
      if (cfg.frame_width == 11'd0) begin
         w = WID_W'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w = WID_W'(MAX_WIDTH);
      end else begin
         w = WID_W'(cfg.frame_width);
      end
      if (cfg.frame_height == 13'd0) begin
         h = HGT_W'(1);
      end else if (32'(cfg.frame_height) > 32'(sgb_pkg::HEIGHT_LIMIT)) begin
         h = HGT_W'(sgb_pkg::HEIGHT_LIMIT);
      end else begin
         h = cfg.frame_height;
      end
      if (32'(cfg.blur_radius) > 32'(MAX_RADIUS)) begin
         rad = RAD_W'(MAX_RADIUS);
      end else begin
         rad = RAD_W'(cfg.blur_radius);
      end
   end

   logic              func_ff;
   logic [23:0]       pix_ff;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [IROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [LIN_W-1:0]  in_lin_ff, in_lin_in;
   logic [LIN_W-1:0]  out_lin_ff, out_lin_in;
   logic [LIN_W-1:0]  total_ff, total_in;
   logic [LIN_W-1:0]  span_ff, span_in;

   logic              bad;
   logic [LIN_W-1:0]  in_eff;
   logic [LIN_W-1:0]  out_eff;
   logic [COL_W-1:0]  ic_eff;
   logic [IROW_W-1:0] ir_eff;
   logic [COL_W-1:0]  oc_eff;
   logic [ROW_W-1:0]  or_eff;
   logic              open;
   logic              write_en;
   logic              last_out;
   logic [LIN_W:0]    need;
   logic [LIN_W:0]    need_min;

   always_comb begin
      bad = (WID_W'(in_col_ff) >= w) || (WID_W'(out_col_ff) >= w) ||
            (in_row_ff > h) || (HGT_W'(out_row_ff) >= h) ||
            (in_lin_ff > total_ff) || (out_lin_ff >= total_ff);
      in_eff   = bad ? '0 : in_lin_ff;
      out_eff  = bad ? '0 : out_lin_ff;
      ic_eff   = bad ? '0 : in_col_ff;
      ir_eff   = bad ? '0 : in_row_ff;
      oc_eff   = bad ? '0 : out_col_ff;
      or_eff   = bad ? '0 : out_row_ff;
      open     = in_eff < total_ff;
      write_en = cmd.update && open && !func_ff;
      last_out = (out_lin_ff + LIN_W'(1)) == total_ff;
      need     = {1'b0, out_lin_ff} + {1'b0, span_ff};
      need_min = (need > {1'b0, total_ff}) ? {1'b0, total_ff} : need;
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      in_lin_in  = in_lin_ff;
      out_lin_in = out_lin_ff;
      total_in   = total_ff;
      span_in    = span_ff;
      if (cmd.calc) begin
         in_lin_in  = LIN_W'(in_row_ff) * LIN_W'(w) + LIN_W'(in_col_ff);
         out_lin_in = LIN_W'(out_row_ff) * LIN_W'(w) + LIN_W'(out_col_ff);
         total_in   = LIN_W'(h) * LIN_W'(w);
         span_in    = LIN_W'(rad) * LIN_W'(w) + LIN_W'(rad) + LIN_W'(1);
      end
      if (cmd.update) begin
         in_col_in  = ic_eff;
         in_row_in  = ir_eff;
         out_col_in = oc_eff;
         out_row_in = or_eff;
         in_lin_in  = in_eff;
         out_lin_in = out_eff;
         if (open && !func_ff) begin
            in_lin_in = in_eff + LIN_W'(1);
            if (WID_W'(ic_eff) + WID_W'(1) >= w) begin
               in_col_in = '0;
               in_row_in = ir_eff + IROW_W'(1);
            end else begin
               in_col_in = ic_eff + COL_W'(1);
            end
         end
      end
      if (cmd.emit) begin
         if (last_out) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (WID_W'(out_col_ff) + WID_W'(1) >= w) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      in_lin_ff  <= in_lin_in;
      out_lin_ff <= out_lin_in;
      total_ff   <= total_in;
      span_ff    <= span_in;
      if (cmd.capture) begin
         func_ff <= req_func;
         pix_ff  <= {req_blue_in, req_green_in, req_red_in};
      end
   end

   logic [23:0] hist_mem [DEPTH];
   logic [ADDR_W-1:0] addr2_ff;
   logic [23:0]       rdata3_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         hist_mem[in_eff[ADDR_W-1:0]] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      rdata3_ff <= hist_mem[addr2_ff];
   end

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] vcnt_ff, vcnt_in;
   logic [CNT_W-1:0] hcnt_ff, hcnt_in;
   logic [CNT_W-1:0] two_rad;
   logic             vlast;
   logic             hlast;
   logic signed [5:0] vr;
   logic signed [5:0] hr;
   tag_type          tag0;
   logic [ROW_W-1:0] yy0;
   logic [COL_W-1:0] xx0;

   always_comb begin
      two_rad = CNT_W'({rad, 1'b0});
      vlast   = vcnt_ff == two_rad;
      hlast   = hcnt_ff == two_rad;
      vr      = signed'(6'(vcnt_ff) - 6'(rad));
      hr      = signed'(6'(hcnt_ff) - 6'(rad));
      tag0.first_v  = vcnt_ff == '0;
      tag0.last_v   = vlast;
      tag0.first_h  = hcnt_ff == '0;
      tag0.last_all = vlast && hlast;
      tag0.vk       = vr[5] ? 4'(-vr) : 4'(vr);
      tag0.hk       = hr[5] ? 4'(-hr) : 4'(hr);
      yy0 = ROW_W'(sgb_pkg::mirror_coord(14'(out_row_ff), vr, 14'(h)));
      xx0 = COL_W'(sgb_pkg::mirror_coord(14'(out_col_ff), hr, 14'(w)));
      busy_in = busy_ff;
      vcnt_in = vcnt_ff;
      hcnt_in = hcnt_ff;
      if (cmd.blur_start) begin
         busy_in = 1'b1;
         vcnt_in = '0;
         hcnt_in = '0;
      end else if (busy_ff) begin
         if (vlast) begin
            vcnt_in = '0;
            if (hlast) begin
               busy_in = 1'b0;
            end else begin
               hcnt_in = hcnt_ff + CNT_W'(1);
            end
         end else begin
            vcnt_in = vcnt_ff + CNT_W'(1);
         end
      end
   end

   logic             valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic             done_ff;
   tag_type          tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [ROW_W-1:0] yy1_ff;
   logic [COL_W-1:0] xx1_ff;
   logic [ACC_W-1:0] vacc_ff [3];
   logic [ACC_W-1:0] hacc_ff [3];
   logic [15:0]      vtap;
   logic [15:0]      htap;

   assign vtap = sgb_pkg::tap_of(cfg.taps, tag3_ff.vk);
   assign htap = sgb_pkg::tap_of(cfg.taps, tag4_ff.hk);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         vcnt_ff   <= '0;
         hcnt_ff   <= '0;
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         vcnt_ff   <= vcnt_in;
         hcnt_ff   <= hcnt_in;
         valid1_ff <= busy_ff;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         done_ff   <= valid4_ff && tag4_ff.last_v && tag4_ff.last_all;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff  <= tag0;
      yy1_ff   <= yy0;
      xx1_ff   <= xx0;
      tag2_ff  <= tag1_ff;
      addr2_ff <= ADDR_W'(PROD_W'(yy1_ff) * PROD_W'(w) + PROD_W'(xx1_ff));
      tag3_ff  <= tag2_ff;
      tag4_ff  <= tag3_ff;
      for (int c = 0; c < 3; c++) begin
         if (valid3_ff) begin
            vacc_ff[c] <= (tag3_ff.first_v ? '0 : vacc_ff[c]) +
                          ACC_W'(vtap * rdata3_ff[8*c +: 8]);
         end
         if (valid4_ff && tag4_ff.last_v) begin
            hacc_ff[c] <= (tag4_ff.first_h ? '0 : hacc_ff[c]) +
                          ACC_W'(htap * sgb_pkg::sat8(32'(vacc_ff[c])));
         end
      end
   end

   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_red_out   <= sgb_pkg::sat8(32'(hacc_ff[0]));
         rsp_green_out <= sgb_pkg::sat8(32'(hacc_ff[1]));
         rsp_blue_out  <= sgb_pkg::sat8(32'(hacc_ff[2]));
         rsp_frame_end <= last_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      status.skip      = open && func_ff;
      status.produce   = {1'b0, in_lin_ff} >= need_min;
      status.blur_done = done_ff;
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

[design/separable_gaussian_blur.sv]
// ----------------------------------------------------------------------------
// Separable blur of an RGB raster stream with mirrored borders
// A drain request ignored before the frame ends returns to idle from the
// update state, any other request that yields no result from the output
// decision. One that yields a result also runs the tap sweep over every tap
// pair of the effective radius, one history memory read per cycle. The output
// register lets a new request in while a result waits. Reset restores the
// configuration registers and clears the row and column position counters;
// the pixel history memory is not cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_gaussian_blur #(
   parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic             rsp_frame_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   sgb_pkg::cfg_type    cfg;
   sgb_pkg::cmd_type    cmd;
   sgb_pkg::status_type status;

   sgb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sgb_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_func),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

[verif/tb_separable_gaussian_blur.sv]
// ----------------------------------------------------------------------------
// Testbench for the separable blur
// Drives whole frames of RGB requests with drain ticks through the block
// under several configurations and idling patterns. A scoreboard predicts
// every blurred pixel and frame end flag and checks the results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_separable_gaussian_blur;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_DEPTH  = sgb_pkg::MAX_WIDTH_DEF * 2 * sgb_pkg::MAX_RADIUS_DEF +
                                2 * sgb_pkg::MAX_RADIUS_DEF + 1;
   localparam int STALL_LIMIT = 20000;
   localparam int BUSY_CYCLES = 20;
   localparam int TAIL_CYCLES = 600;
   localparam int RANDOM_ITEMS = 800;
   localparam int PARTIAL_ROWS = 100;

   typedef enum logic {FUNC_PIXEL = 1'b0, FUNC_DRAIN = 1'b1} func_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_pixel_type;

   class blur_scoreboard;
      logic [23:0]    history [HIST_DEPTH];
      logic [10:0]    frame_width;
      logic [12:0]    frame_height;
      logic [3:0]     blur_radius;
      logic [191:0]   taps;
      int unsigned    in_col, in_row, out_col, out_row;
      blur_pixel_type expected_q[$];
      int             mismatches;
      int             results;

      function new();
         foreach (history[i]) history[i] = '0;
         frame_width  = sgb_pkg::FRAME_WIDTH_RST;
         frame_height = sgb_pkg::FRAME_HEIGHT_RST;
         blur_radius  = sgb_pkg::BLUR_RADIUS_RST;
         taps         = {128'd0, sgb_pkg::TAP_LOW_RST};
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         mismatches = 0;
         results = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [63:0] data);
         case (index)
            sgb_pkg::CSR_FRAME_WIDTH: frame_width = data[10:0];
            sgb_pkg::CSR_FRAME_HEIGHT: frame_height = data[12:0];
            sgb_pkg::CSR_BLUR_RADIUS: blur_radius = data[3:0];
            sgb_pkg::CSR_TAP_LOW: taps[63:0] = data;
            sgb_pkg::CSR_TAP_MID: taps[127:64] = data;
            sgb_pkg::CSR_TAP_HIGH: taps[191:128] = data;
            default: ;
         endcase
      endfunction

      function int unsigned eff_width();
         return frame_width < 1 ? 1 :
                (frame_width > sgb_pkg::MAX_WIDTH_DEF ? sgb_pkg::MAX_WIDTH_DEF : frame_width);
      endfunction

      function int unsigned eff_height();
         return frame_height < 1 ? 1 :
                (frame_height > sgb_pkg::HEIGHT_LIMIT ? sgb_pkg::HEIGHT_LIMIT : frame_height);
      endfunction

      function int unsigned eff_radius();
         return blur_radius > sgb_pkg::MAX_RADIUS_DEF ? sgb_pkg::MAX_RADIUS_DEF : blur_radius;
      endfunction

      function int unsigned frame_pixels();
         return eff_width() * eff_height();
      endfunction

      function int unsigned drain_count();
         int unsigned lag;
         lag = eff_radius() * eff_width() + eff_radius();
         return lag >= frame_pixels() ? frame_pixels() - 1 : lag;
      endfunction

      function int reflect(int c, int r, int n);
         int p;
         p = c + r;
         if (p < 0 || p >= n) p = c - r;
         if (p < 0) p = 0;
         if (p >= n) p = n - 1;
         return p;
      endfunction

      function logic [7:0] clip(logic [31:0] acc);
         return (acc >> 15) > 255 ? 8'hFF : 8'(acc >> 15);
      endfunction

      function logic [23:0] weigh(logic [23:0] px [], int rad);
         logic [31:0] acc [3];
         logic [31:0] t;
         acc = '{0, 0, 0};
         for (int d = -rad; d <= rad; d++) begin
            t = taps[(d < 0 ? -d : d) * 16 +: 16];
            for (int c = 0; c < 3; c++) acc[c] += t * px[d + rad][8 * c +: 8];
         end
         return {clip(acc[2]), clip(acc[1]), clip(acc[0])};
      endfunction

      function logic [23:0] column_pass(int y, int x, int w, int h, int rad);
         logic [23:0] px [];
         int unsigned lin;
         px = new[2 * rad + 1];
         for (int d = -rad; d <= rad; d++) begin
            lin = reflect(y, d, h) * w + x;
            px[d + rad] = history[lin % HIST_DEPTH];
         end
         return weigh(px, rad);
      endfunction

      function logic [23:0] blur_pixel(int y, int x, int w, int h, int rad);
         logic [23:0] px [];
         px = new[2 * rad + 1];
         for (int d = -rad; d <= rad; d++)
            px[d + rad] = column_pass(y, reflect(x, d, w), w, h, rad);
         return weigh(px, rad);
      endfunction

      function void note_request(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int unsigned w, h, rad, total, in_lin, out_lin, need;
         logic [23:0] px;
         blur_pixel_type e;
         w = eff_width();
         h = eff_height();
         rad = eff_radius();
         total = w * h;
         in_lin = in_row * w + in_col;
         out_lin = out_row * w + out_col;
         if (in_col >= w || out_col >= w || in_row > h || out_row >= h ||
             in_lin > total || out_lin >= total) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            in_lin = 0; out_lin = 0;
         end
         if (in_lin < total) begin
            if (func == FUNC_DRAIN) return;
            history[in_lin % HIST_DEPTH] = {b, g, r};
            in_lin++;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
            end
         end
         need = out_lin + rad * w + rad + 1;
         if (need > total) need = total;
         if (in_lin < need) return;
         px = blur_pixel(out_row, out_col, w, h, rad);
         e.red = px[7:0];
         e.green = px[15:8];
         e.blue = px[23:16];
         e.frame_end = (out_lin + 1 == total);
         expected_q.push_back(e);
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         if (e.frame_end) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
      endfunction

      function void check_result(blur_pixel_type got);
         blur_pixel_type e;
         results++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: r=%0d g=%0d b=%0d end=%0b",
                        got.red, got.green, got.blue, got.frame_end);
            return;
         end
         e = expected_q.pop_front();
         if (e != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: expected r=%0d g=%0d b=%0d end=%0b, %s%0d %s%0d %s%0d %s%0b",
                        results, e.red, e.green, e.blue, e.frame_end,
                        "got r=", got.red, "g=", got.green, "b=", got.blue,
                        "end=", got.frame_end);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_frame_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   blur_scoreboard scoreboard = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int requests = 0;
   int frames = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   separable_gaussian_blur i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_red_out(rsp_red_out),
      .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      blur_pixel_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.red = rsp_red_out;
            got.green = rsp_green_out;
            got.blue = rsp_blue_out;
            got.frame_end = rsp_frame_end;
            scoreboard.check_result(got);
         end
         if (req_valid && req_ready) begin
            scoreboard.note_request(req_func, req_red_in, req_green_in, req_blue_in);
            requests++;
         end
         if (csr_valid && csr_ready) begin
            scoreboard.write_reg(csr_index, csr_wdata);
            csr_writes++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_request(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_red_in <= r;
      req_green_in <= g;
      req_blue_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (scoreboard.expected_q.size() != 0) @(negedge clock);
      repeat (BUSY_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] index, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [10:0] w, logic [12:0] h, logic [3:0] r,
                            logic [63:0] t_low, logic [63:0] t_mid, logic [63:0] t_high);
      wait_idle();
      csr_write(sgb_pkg::CSR_FRAME_WIDTH, 64'(w));
      csr_write(sgb_pkg::CSR_FRAME_HEIGHT, 64'(h));
      csr_write(sgb_pkg::CSR_BLUR_RADIUS, 64'(r));
      csr_write(sgb_pkg::CSR_TAP_LOW, t_low);
      csr_write(sgb_pkg::CSR_TAP_MID, t_mid);
      csr_write(sgb_pkg::CSR_TAP_HIGH, t_high);
   endtask

   function automatic logic [7:0] shade();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] tap_word(int rad);
      logic [63:0] word;
      int unsigned top;
      if ($urandom_range(3) == 0) return {$urandom, $urandom};
      top = 32768 / (2 * rad + 1) + 1;
      for (int k = 0; k < 4; k++) word[16 * k +: 16] = 16'($urandom_range(top));
      return word;
   endfunction

   task automatic run_frame(output int sent);
      int unsigned total, tail;
      total = scoreboard.frame_pixels();
      tail = scoreboard.drain_count();
      sent = 0;
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(99) < 4) begin
            push_request(FUNC_DRAIN, shade(), shade(), shade());
         end
         push_request(FUNC_PIXEL, shade(), shade(), shade());
         sent++;
      end
      for (int unsigned i = 0; i < tail; i++) begin
         push_request($urandom_range(9) == 0 ? FUNC_PIXEL : FUNC_DRAIN,
                      shade(), shade(), shade());
         sent++;
      end
      frames++;
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 62; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 62; end
         default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
   endtask

   initial begin
      int sent;
      int random_sent;
      int phase;
      int unsigned rad;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Small frame with saturating taps, then extremes of every register.
      configure(11'd3, 13'd2, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
      push_request(FUNC_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      run_frame(sent);
      configure(11'd5, 13'd4, 4'd15, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
      run_frame(sent);
      configure(11'd7, 13'd7, 4'd3, 64'h0800_1000_1800_2000, 64'd0, 64'd0);
      run_frame(sent);
      configure(11'd2047, 13'd1, 4'd0, 64'h0000_0000_0000_8000, 64'd0, 64'd0);
      run_frame(sent);

      // The tall frame is only started; the next frame size abandons it.
      configure(11'd0, 13'd8191, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd0);
      repeat (PARTIAL_ROWS) push_request(FUNC_PIXEL, shade(), shade(), shade());
      configure(11'd1, 13'd0, 4'd2, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      run_frame(sent);

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         set_idling(phase);
         if ($urandom_range(9) == 0) begin
            rad = $urandom_range(4, 15);
            configure(11'($urandom_range(1, 4)), 13'($urandom_range(1, 4)), 4'(rad),
                      tap_word(11), tap_word(11), tap_word(11));
         end else begin
            rad = $urandom_range(0, 3);
            configure(11'($urandom_range(1, 12)), 13'($urandom_range(1, 10)), 4'(rad),
                      tap_word(rad), tap_word(rad), tap_word(rad));
         end
         repeat (3) begin
            run_frame(sent);
            random_sent += sent;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (scoreboard.expected_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d requests in %0d frames, %0d results, %0d register writes.",
               requests, frames, scoreboard.results, csr_writes);
      $display("Radius, frame size and tap extremes ran under four idling patterns.");
      if (scoreboard.mismatches == 0 && scoreboard.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("Mismatches: %0d", scoreboard.mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
